// ===== design/mtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_pkg
// Types and constants shared by the move-to-point velocity limiter.
// ----------------------------------------------------------------------------
package mtp_pkg;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic [22:0]        velocity_limit;
        logic [22:0]        accel_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] velocity_x;
        logic signed [23:0] velocity_y;
        logic               arrived;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_ARR,
        S_ROOT,
        S_SAFE_MUL,
        S_SAFE_ROOT,
        S_TX_MUL,
        S_TX_DIV,
        S_TY_MUL,
        S_TY_DIV,
        S_DV,
        S_LIM,
        S_LIM_SQ,
        S_DX_SQ,
        S_DY_SQ,
        S_CMP,
        S_DLEN,
        S_SX_MUL,
        S_SX_DIV,
        S_SY_MUL,
        S_SY_DIV,
        S_UPD
    } t_state;

    localparam logic [1:0]  REG_TARGET_X       = 2'd0;
    localparam logic [1:0]  REG_TARGET_Y       = 2'd1;
    localparam logic [1:0]  REG_VELOCITY_LIMIT = 2'd2;
    localparam logic [1:0]  REG_ACCEL_LIMIT    = 2'd3;

    localparam logic [22:0] VLIM_RESET  = 23'd65536;
    localparam logic [22:0] ALIM_RESET  = 23'd131072;
    localparam logic [63:0] ARRIVE_MUL  = 64'd25;
    localparam logic [63:0] ARRIVE_LIM  = 64'h0000_0000_1000_0000;
    localparam logic [63:0] TICK_RATE   = 64'd200;
    localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;
    localparam logic signed [27:0] VEL_MAX = 28'sd8388607;
    localparam logic signed [27:0] VEL_MIN = -28'sd8388608;

endpackage
`default_nettype wire

// ===== design/mtp_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_regs
// APB register file: target position, velocity and acceleration limits.
// ----------------------------------------------------------------------------
module mtp_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mtp_pkg::t_cfg      o_cfg
);
    import mtp_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_x       <= '0;
            r_cfg.target_y       <= '0;
            r_cfg.velocity_limit <= VLIM_RESET;
            r_cfg.accel_limit    <= ALIM_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_TARGET_X:       r_cfg.target_x       <= pwdata;
                REG_TARGET_Y:       r_cfg.target_y       <= pwdata;
                REG_VELOCITY_LIMIT: r_cfg.velocity_limit <= pwdata[22:0];
                REG_ACCEL_LIMIT:    r_cfg.accel_limit    <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TARGET_X:       prdata = r_cfg.target_x;
            REG_TARGET_Y:       prdata = r_cfg.target_y;
            REG_VELOCITY_LIMIT: prdata = {9'd0, r_cfg.velocity_limit};
            REG_ACCEL_LIMIT:    prdata = {9'd0, r_cfg.accel_limit};
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/mtp_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtp_alu
// Shared bit-serial unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
module mtp_alu (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mtp_pkg::t_alu_req i_req,
    output mtp_pkg::t_alu_rsp  o_rsp
);
    import mtp_pkg::*;

    logic        r_run;
    logic        r_done;
    t_alu_op     r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_acc;
    logic [63:0] r_aux;

    logic [64:0] w_trem;
    logic [63:0] w_trial;
    logic        w_last;

    assign w_trem  = {r_acc, r_y[63]};
    assign w_trial = r_acc + r_aux;
    assign w_last  = (r_op == ALU_SQRT) ? (r_cnt == 6'd31) : (r_cnt == 6'd63);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && w_last) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            case (i_req.op)
                ALU_MUL: begin
                    r_x   <= i_req.a;
                    r_y   <= i_req.b;
                    r_acc <= '0;
                end
                ALU_DIV: begin
                    r_y   <= i_req.a;
                    r_x   <= i_req.b;
                    r_acc <= '0;
                end
                default: begin
                    r_y   <= i_req.a;
                    r_acc <= '0;
                    r_aux <= SQRT_BIT0;
                end
            endcase
        end else if (r_run) begin
            r_cnt <= r_cnt + 6'd1;
            case (r_op)
                ALU_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end
                ALU_DIV: begin
                    if (w_trem >= {1'b0, r_x}) begin
                        r_acc <= 64'(w_trem - {1'b0, r_x});
                        r_y   <= {r_y[62:0], 1'b1};
                    end else begin
                        r_acc <= w_trem[63:0];
                        r_y   <= {r_y[62:0], 1'b0};
                    end
                end
                default: begin
                    if (r_y >= w_trial) begin
                        r_y   <= r_y - w_trial;
                        r_acc <= (r_acc >> 1) + r_aux;
                    end else begin
                        r_acc <= r_acc >> 1;
                    end
                    r_aux <= r_aux >> 2;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.busy = r_run;
        o_rsp.done = r_done;
        case (r_op)
            ALU_DIV: o_rsp.result = r_y;
            default: o_rsp.result = r_acc;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/move_to_point_velocity_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_point_velocity_limiter
// Per-tick commanded velocity towards a target with speed and step limits.
// ----------------------------------------------------------------------------
// Every multiply, divide and root runs on one shared serial unit. An item
// inside the arrival radius skips the speed and step computation; one whose
// step is clamped takes a further root, two multiplies and two divides.
// One item at a time: input stalls until the result is registered. Synchronous
// reset clears the command to zero and loads the register defaults.
module move_to_point_velocity_limiter (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire mtp_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output mtp_pkg::t_out_item  o_out_item,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mtp_pkg::*;

    t_cfg     w_cfg;
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    t_state r_state, n_state;
    logic   r_issued;
    logic   r_ovalid;
    t_out_item r_out;

    logic signed [32:0] r_ex, r_ey;
    logic               r_arr;
    logic [63:0]        r_sum;
    logic [32:0]        r_dist;
    logic [22:0]        r_speed;
    logic [63:0]        r_prod;
    logic signed [25:0] r_tvx, r_tvy;
    logic [15:0]        r_lim;
    logic [31:0]        r_limsq;
    logic [63:0]        r_dsq;
    logic [26:0]        r_dlen;
    logic signed [26:0] r_dvx, r_dvy;
    logic signed [23:0] r_cmdx, r_cmdy;

    logic [32:0]        w_ax, w_ay;
    logic               w_sh;
    logic [31:0]        w_bx, w_by;
    logic [26:0]        w_adx, w_ady;
    logic [34:0]        w_reach;
    logic [63:0]        w_min;
    logic [22:0]        w_speed;
    logic signed [25:0] w_q;
    logic signed [27:0] w_nx, w_ny;
    logic               w_op;
    logic               w_out_free;

    mtp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mtp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_ax  = r_ex[32] ? 33'(-r_ex) : 33'(r_ex);
    assign w_ay  = r_ey[32] ? 33'(-r_ey) : 33'(r_ey);
    assign w_sh  = (|w_ax[32:31]) | (|w_ay[32:31]);
    assign w_bx  = 32'(w_ax >> w_sh);
    assign w_by  = 32'(w_ay >> w_sh);
    assign w_adx = r_dvx[26] ? 27'(-r_dvx) : 27'(r_dvx);
    assign w_ady = r_dvy[26] ? 27'(-r_dvy) : 27'(r_dvy);

    assign w_reach = {1'b0, r_dist, 1'b0} + {2'b0, r_dist};
    assign w_min   = ({29'd0, w_reach} < w_rsp.result) ? {29'd0, w_reach} : w_rsp.result;
    assign w_speed = ({41'd0, w_cfg.velocity_limit} < w_min) ? w_cfg.velocity_limit
                                                             : w_min[22:0];
    assign w_q     = $signed({1'b0, w_rsp.result[24:0]});
    assign w_nx    = 28'(r_cmdx) + 28'(r_dvx);
    assign w_ny    = 28'(r_cmdy) + 28'(r_dvy);

    assign w_out_free  = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SQX;
            S_SQX:       if (w_rsp.done) n_state = S_SQY;
            S_SQY:       if (w_rsp.done) n_state = S_ARR;
            S_ARR: begin
                if (w_rsp.done) begin
                    n_state = (!w_sh && w_rsp.result < ARRIVE_LIM) ? S_UPD : S_ROOT;
                end
            end
            S_ROOT:      if (w_rsp.done) n_state = S_SAFE_MUL;
            S_SAFE_MUL:  if (w_rsp.done) n_state = S_SAFE_ROOT;
            S_SAFE_ROOT: if (w_rsp.done) n_state = S_TX_MUL;
            S_TX_MUL:    if (w_rsp.done) n_state = S_TX_DIV;
            S_TX_DIV:    if (w_rsp.done) n_state = S_TY_MUL;
            S_TY_MUL:    if (w_rsp.done) n_state = S_TY_DIV;
            S_TY_DIV:    if (w_rsp.done) n_state = S_DV;
            S_DV:        n_state = S_LIM;
            S_LIM:       if (w_rsp.done) n_state = S_LIM_SQ;
            S_LIM_SQ:    if (w_rsp.done) n_state = S_DX_SQ;
            S_DX_SQ:     if (w_rsp.done) n_state = S_DY_SQ;
            S_DY_SQ:     if (w_rsp.done) n_state = S_CMP;
            S_CMP:       n_state = (r_dsq > {32'd0, r_limsq}) ? S_DLEN : S_UPD;
            S_DLEN:      if (w_rsp.done) n_state = S_SX_MUL;
            S_SX_MUL:    if (w_rsp.done) n_state = S_SX_DIV;
            S_SX_DIV:    if (w_rsp.done) n_state = S_SY_MUL;
            S_SY_MUL:    if (w_rsp.done) n_state = S_SY_DIV;
            S_SY_DIV:    if (w_rsp.done) n_state = S_UPD;
            S_UPD:       if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_op       = 1'b1;
        w_req.op   = ALU_MUL;
        w_req.a    = '0;
        w_req.b    = '0;
        unique case (r_state)
            S_SQX: begin
                w_req.a = {32'd0, w_bx};
                w_req.b = {32'd0, w_bx};
            end
            S_SQY: begin
                w_req.a = {32'd0, w_by};
                w_req.b = {32'd0, w_by};
            end
            S_ARR: begin
                w_req.a = r_sum;
                w_req.b = ARRIVE_MUL;
            end
            S_ROOT: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_sum;
            end
            S_SAFE_MUL: begin
                w_req.a = {40'd0, w_cfg.accel_limit, 1'b0};
                w_req.b = {31'd0, r_dist};
            end
            S_SAFE_ROOT: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_prod;
            end
            S_TX_MUL: begin
                w_req.a = {31'd0, w_ax};
                w_req.b = {41'd0, r_speed};
            end
            S_TY_MUL: begin
                w_req.a = {31'd0, w_ay};
                w_req.b = {41'd0, r_speed};
            end
            S_TX_DIV, S_TY_DIV: begin
                w_req.op = ALU_DIV;
                w_req.a  = r_prod;
                w_req.b  = {31'd0, r_dist};
            end
            S_LIM: begin
                w_req.op = ALU_DIV;
                w_req.a  = {41'd0, w_cfg.accel_limit};
                w_req.b  = TICK_RATE;
            end
            S_LIM_SQ: begin
                w_req.a = {48'd0, r_lim};
                w_req.b = {48'd0, r_lim};
            end
            S_DX_SQ: begin
                w_req.a = {37'd0, w_adx};
                w_req.b = {37'd0, w_adx};
            end
            S_DY_SQ: begin
                w_req.a = {37'd0, w_ady};
                w_req.b = {37'd0, w_ady};
            end
            S_DLEN: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_dsq;
            end
            S_SX_MUL: begin
                w_req.a = {37'd0, w_adx};
                w_req.b = {48'd0, r_lim};
            end
            S_SY_MUL: begin
                w_req.a = {37'd0, w_ady};
                w_req.b = {48'd0, r_lim};
            end
            S_SX_DIV, S_SY_DIV: begin
                w_req.op = ALU_DIV;
                w_req.a  = r_prod;
                w_req.b  = {37'd0, r_dlen};
            end
            default: w_op = 1'b0;
        endcase
        w_req.start = w_op && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_cmdx   <= '0;
            r_cmdy   <= '0;
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (r_state == S_UPD && w_out_free) begin
                r_ovalid <= 1'b1;
                if (r_arr) begin
                    r_cmdx <= '0;
                    r_cmdy <= '0;
                end else begin
                    r_cmdx <= (w_nx > VEL_MAX) ? 24'(VEL_MAX) :
                              (w_nx < VEL_MIN) ? 24'(VEL_MIN) : 24'(w_nx);
                    r_cmdy <= (w_ny > VEL_MAX) ? 24'(VEL_MAX) :
                              (w_ny < VEL_MIN) ? 24'(VEL_MIN) : 24'(w_ny);
                end
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ex <= 33'(w_cfg.target_x) - 33'(i_in_item.position_x);
                r_ey <= 33'(w_cfg.target_y) - 33'(i_in_item.position_y);
            end
            S_SQX:       if (w_rsp.done) r_sum <= w_rsp.result;
            S_SQY:       if (w_rsp.done) r_sum <= r_sum + w_rsp.result;
            S_ARR: begin
                if (w_rsp.done) begin
                    r_arr <= !w_sh && (w_rsp.result < ARRIVE_LIM);
                end
            end
            S_ROOT:      if (w_rsp.done) r_dist <= {1'b0, w_rsp.result[31:0]} << w_sh;
            S_SAFE_MUL:  if (w_rsp.done) r_prod <= w_rsp.result;
            S_SAFE_ROOT: if (w_rsp.done) r_speed <= w_speed;
            S_TX_MUL, S_TY_MUL, S_SX_MUL, S_SY_MUL: begin
                if (w_rsp.done) r_prod <= w_rsp.result;
            end
            S_TX_DIV:    if (w_rsp.done) r_tvx <= r_ex[32] ? -w_q : w_q;
            S_TY_DIV:    if (w_rsp.done) r_tvy <= r_ey[32] ? -w_q : w_q;
            S_DV: begin
                r_dvx <= 27'(r_tvx) - 27'(r_cmdx);
                r_dvy <= 27'(r_tvy) - 27'(r_cmdy);
            end
            S_LIM:       if (w_rsp.done) r_lim <= w_rsp.result[15:0];
            S_LIM_SQ:    if (w_rsp.done) r_limsq <= w_rsp.result[31:0];
            S_DX_SQ:     if (w_rsp.done) r_dsq <= w_rsp.result;
            S_DY_SQ:     if (w_rsp.done) r_dsq <= r_dsq + w_rsp.result;
            S_DLEN:      if (w_rsp.done) r_dlen <= w_rsp.result[26:0];
            S_SX_DIV: begin
                if (w_rsp.done) begin
                    r_dvx <= r_dvx[26] ? -$signed({1'b0, w_rsp.result[25:0]})
                                       : $signed({1'b0, w_rsp.result[25:0]});
                end
            end
            S_SY_DIV: begin
                if (w_rsp.done) begin
                    r_dvy <= r_dvy[26] ? -$signed({1'b0, w_rsp.result[25:0]})
                                       : $signed({1'b0, w_rsp.result[25:0]});
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    r_out.arrived <= r_arr;
                    if (r_arr) begin
                        r_out.velocity_x <= '0;
                        r_out.velocity_y <= '0;
                    end else begin
                        r_out.velocity_x <= (w_nx > VEL_MAX) ? 24'(VEL_MAX) :
                                            (w_nx < VEL_MIN) ? 24'(VEL_MIN) : 24'(w_nx);
                        r_out.velocity_y <= (w_ny > VEL_MAX) ? 24'(VEL_MAX) :
                                            (w_ny < VEL_MIN) ? 24'(VEL_MIN) : 24'(w_ny);
                    end
                end
            end
            default: ;
        endcase
    end

    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.arrived |->
            o_out_item.velocity_x == 24'sd0 && o_out_item.velocity_y == 24'sd0)
        else $error("arrived item with nonzero velocity");

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("serial unit started while busy");

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_issued)
        else $error("serial unit result without request");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_UPD))
        else $error("result raised outside update");

endmodule
`default_nettype wire
